// File: rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-wire bus master
// command codes, phase encoding, register indexes and reset values
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;
    localparam int CNT_W         = 10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_WAIT = 6'b000100,
        PH_RST_REST = 6'b001000,
        PH_WRITE    = 6'b010000,
        PH_READ     = 6'b100000
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_REST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;

    localparam logic [9:0] RST_RESET_LOW     = 10'd480;
    localparam logic [7:0] RST_PRESENCE_WAIT = 8'd70;
    localparam logic [9:0] RST_PRESENCE_REST = 10'd410;
    localparam logic [5:0] RST_ONE_LOW       = 6'd6;
    localparam logic [6:0] RST_ZERO_LOW      = 7'd60;
    localparam logic [7:0] RST_SLOT          = 8'd70;
    localparam logic [6:0] RST_READ_SAMPLE   = 7'd15;

    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

    // classified command as it sits in the queue
    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       bus_level;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

// File: rtl/core/owbm_req_if.sv
// ----------------------------------------------------------------------------
// owbm_req_if: command and tick channel
// valid/ready handshake carrying func, data_byte and bus_level
// ----------------------------------------------------------------------------
interface owbm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       bus_level;

    modport source (output valid, output func, output data_byte, output bus_level,
                    input ready);
    modport sink (input valid, input func, input data_byte, input bus_level,
                  output ready);
endinterface

// File: rtl/core/owbm_rsp_if.sv
// ----------------------------------------------------------------------------
// owbm_rsp_if: result channel
// valid/ready handshake carrying bus drive, status flags and read byte
// ----------------------------------------------------------------------------
interface owbm_rsp_if;
    logic       valid;
    logic       ready;
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_seen;
    logic [7:0] read_value;

    modport source (output valid, output pull_low, output busy_res, output done_res,
                    output presence_seen, output read_value, input ready);
    modport sink (input valid, input pull_low, input busy_res, input done_res,
                  input presence_seen, input read_value, output ready);
endinterface

// File: rtl/core/owbm_cfg_if.sv
// ----------------------------------------------------------------------------
// owbm_cfg_if: register write channel
// valid/ready handshake carrying register index and write data
// ----------------------------------------------------------------------------
interface owbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/owbm_front.sv
// ----------------------------------------------------------------------------
// owbm_front: input stage
// accepts items while the queue has room and classifies the function code
// ----------------------------------------------------------------------------
module owbm_front (
    owbm_req_if.sink          req,
    input  logic              q_full,
    output owbm_pkg::q_push_t push
);
    import owbm_pkg::*;

    op_t op;

    always_comb
    begin
        unique case (req.func)
            2'd1:    op = OP_RESET;
            2'd2:    op = OP_WRITE;
            2'd3:    op = OP_READ;
            default: op = OP_TICK;
        endcase
    end

    assign req.ready = !q_full;

    always_comb
    begin
        push.valid         = req.valid && !q_full;
        push.cmd.op        = op;
        // data only matters for a write start, level only for a tick
        push.cmd.data_byte = (op == OP_WRITE) ? req.data_byte : 8'd0;
        push.cmd.bus_level = (op == OP_TICK) ? req.bus_level : 1'b1;
    end

endmodule

// File: rtl/core/owbm_queue.sv
// ----------------------------------------------------------------------------
// owbm_queue: command queue
// small fifo between the front and back stages
// ----------------------------------------------------------------------------
module owbm_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  owbm_pkg::q_push_t push,
    input  logic              pop,
    output logic              full,
    output owbm_pkg::q_head_t head
);
    import owbm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("push into a full command queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push.valid && count_reg == CW'(1)) |=> !head.valid)
        else $error("queue not empty after last pop");
`endif

endmodule

// File: rtl/core/owbm_back.sv
// ----------------------------------------------------------------------------
// owbm_back: bus sequencer
// runs the reset, write and read phases one item per cycle while rsp does not
// stall, holds the timing registers and the result register
// ----------------------------------------------------------------------------
module owbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  owbm_pkg::q_head_t head,
    output logic              pop,
    owbm_cfg_if.sink          cfg,
    owbm_rsp_if.source        rsp
);
    import owbm_pkg::*;

    // timing registers
    logic [9:0] reset_low_reg;
    logic [7:0] presence_wait_reg;
    logic [9:0] presence_rest_reg;
    logic [5:0] one_low_reg;
    logic [6:0] zero_low_reg;
    logic [7:0] slot_reg;
    logic [6:0] read_sample_reg;

    // sequencer state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] tick_count_reg, tick_count_next;
    logic [2:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_reg, shift_next;
    logic             presence_reg, presence_next;
    logic [7:0]       last_read_reg, last_read_next;
    logic             drive_reg, drive_next;
    logic             done;

    // result register
    logic             out_valid_reg;
    logic             out_pull_low_reg, out_busy_reg, out_done_reg, out_presence_reg;
    logic [7:0]       out_read_reg;

    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       slot_len;
    logic [9:0]       reset_len;
    logic [7:0]       wait_len;
    logic [6:0]       sample_raw;
    logic [7:0]       sample_pt;
    logic [6:0]       low_len;
    logic             step;

    assign step    = head.valid && (!out_valid_reg || rsp.ready);
    assign pop     = step;
    assign cfg.ready = 1'b1;

    assign cnt_inc    = tick_count_reg + 1'b1;
    assign slot_len   = (slot_reg == '0) ? 8'd1 : slot_reg;
    assign reset_len  = (reset_low_reg == '0) ? 10'd1 : reset_low_reg;
    assign wait_len   = (presence_wait_reg == '0) ? 8'd1 : presence_wait_reg;
    assign sample_raw = (read_sample_reg == '0) ? 7'd1 : read_sample_reg;
    assign sample_pt  = ({1'b0, sample_raw} > slot_len) ? slot_len : {1'b0, sample_raw};
    assign low_len    = shift_reg[0] ? {1'b0, one_low_reg} : zero_low_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        presence_next   = presence_reg;
        last_read_next  = last_read_reg;
        drive_next      = drive_reg;
        done            = 1'b0;

        if (head.cmd.op != OP_TICK)
        begin
            // a command while busy is dropped
            if (phase_reg == PH_IDLE)
            begin
                tick_count_next = '0;
                bit_index_next  = '0;
                drive_next      = 1'b1;
                unique case (head.cmd.op)
                    OP_RESET:
                    begin
                        phase_next    = PH_RST_LOW;
                        presence_next = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        phase_next = PH_WRITE;
                        shift_next = head.cmd.data_byte;
                    end
                    default:
                    begin
                        phase_next = PH_READ;
                        shift_next = '0;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_count_next = cnt_inc;
            unique case (phase_reg)
                PH_RST_LOW:
                begin
                    drive_next = 1'b1;
                    if (cnt_inc >= reset_len)
                    begin
                        phase_next      = PH_RST_WAIT;
                        tick_count_next = '0;
                        drive_next      = 1'b0;
                    end
                end
                PH_RST_WAIT:
                begin
                    drive_next = 1'b0;
                    if (cnt_inc >= {2'b00, wait_len})
                    begin
                        presence_next   = !head.cmd.bus_level;
                        tick_count_next = '0;
                        if (presence_rest_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RST_REST;
                        end
                    end
                end
                PH_RST_REST:
                begin
                    drive_next = 1'b0;
                    if (cnt_inc >= presence_rest_reg)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_WRITE:
                begin
                    drive_next = (cnt_inc < {3'b000, low_len});
                    if (cnt_inc >= {2'b00, slot_len})
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        if (bit_index_reg == LAST_BIT)
                        begin
                            bit_index_next = '0;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                        else
                        begin
                            bit_index_next  = bit_index_reg + 1'b1;
                            tick_count_next = '0;
                            drive_next      = 1'b1;
                        end
                    end
                end
                PH_READ:
                begin
                    drive_next = (cnt_inc < {4'b0000, one_low_reg});
                    if (cnt_inc == {2'b00, sample_pt})
                    begin
                        shift_next = {head.cmd.bus_level, shift_reg[7:1]};
                    end
                    if (cnt_inc >= {2'b00, slot_len})
                    begin
                        if (bit_index_reg == LAST_BIT)
                        begin
                            bit_index_next = '0;
                            last_read_next = shift_next;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                        else
                        begin
                            bit_index_next  = bit_index_reg + 1'b1;
                            tick_count_next = '0;
                            drive_next      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (phase_next == PH_IDLE)
        begin
            drive_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg     <= RST_RESET_LOW;
            presence_wait_reg <= RST_PRESENCE_WAIT;
            presence_rest_reg <= RST_PRESENCE_REST;
            one_low_reg       <= RST_ONE_LOW;
            zero_low_reg      <= RST_ZERO_LOW;
            slot_reg          <= RST_SLOT;
            read_sample_reg   <= RST_READ_SAMPLE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RESET_LOW:     reset_low_reg     <= cfg.data;
                CFG_PRESENCE_WAIT: presence_wait_reg <= cfg.data[7:0];
                CFG_PRESENCE_REST: presence_rest_reg <= cfg.data;
                CFG_ONE_LOW:       one_low_reg       <= cfg.data[5:0];
                CFG_ZERO_LOW:      zero_low_reg      <= cfg.data[6:0];
                CFG_SLOT:          slot_reg          <= cfg.data[7:0];
                CFG_READ_SAMPLE:   read_sample_reg   <= cfg.data[6:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            presence_reg   <= 1'b0;
            last_read_reg  <= '0;
            drive_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            presence_reg   <= presence_next;
            last_read_reg  <= last_read_next;
            drive_reg      <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_pull_low_reg <= drive_next;
            out_busy_reg     <= (phase_next != PH_IDLE);
            out_done_reg     <= done;
            out_presence_reg <= presence_next;
            out_read_reg     <= last_read_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.pull_low      = out_pull_low_reg;
    assign rsp.busy_res      = out_busy_reg;
    assign rsp.done_res      = out_done_reg;
    assign rsp.presence_seen = out_presence_reg;
    assign rsp.read_value    = out_read_reg;

`ifndef SYNTHESIS
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> !drive_reg)
        else $error("bus driven low while idle");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.done_res) |-> !rsp.busy_res)
        else $error("done reported while still busy");
    a_bit_index_in_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_index_reg != '0) |-> (phase_reg == PH_WRITE || phase_reg == PH_READ))
        else $error("bit index left over outside a byte transfer");
    a_start_drives_low: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && head.cmd.op != OP_TICK) |=> drive_reg)
        else $error("command start did not pull the bus low");
`endif

endmodule

// File: rtl/core/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-wire bus master paced by microsecond ticks
// front stage, command queue and bus sequencer with result register
// ----------------------------------------------------------------------------
// usage
//   req: one item per transfer; func 0 is a one-microsecond tick carrying the
//     sampled bus level, 1 starts a reset with presence detect, 2 writes
//     data_byte, 3 reads a byte. a command arriving while busy is ignored.
//   rsp: exactly one result per request item, in order: pull_low drive for
//     the open-drain pad, busy and done flags, presence and last read byte.
//   cfg: register writes (index 0..6, timing tick counts), always ready;
//     write only while the block is idle.
// throughput: one item per cycle while rsp does not stall, set by the sequencer step.
// path: a request item is written into the queue, then stepped from the queue
//   into the result register once that register is free or its result is taken.
// reset: timing registers return to their defaults, the bus is released,
//   queue and result register are empty.
// stall: while rsp is not taken the result is held and items pile up in the
//   queue; req.ready falls only once the queue is full.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    owbm_req_if.sink    req,
    owbm_rsp_if.source  rsp,
    owbm_cfg_if.sink    cfg
);
    import owbm_pkg::*;

    q_push_t push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    owbm_front u_front (
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    owbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    owbm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .cfg   (cfg),
        .rsp   (rsp)
    );

endmodule

// File: dv/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb: self-checking bench for the 1-wire bus master
// a directed table runs reset, write and read under short fixed timings, then
// phases at edge and random timings with random bus levels and commands. every
// result transfer is compared field by field with a typed-in value or an in-bench bus predictor
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;
    import owbm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_PERCENT    = 13;
    localparam int RAND_PHASES     = 6;
    localparam int PHASE_ITEMS     = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_ROWS          = 22;

    // timings for the directed table
    localparam logic [9:0] DIR_RESET_LOW     = 10'd24;
    localparam logic [9:0] DIR_PRESENCE_WAIT = 10'd6;
    localparam logic [9:0] DIR_PRESENCE_REST = 10'd16;
    localparam logic [9:0] DIR_ONE_LOW       = 10'd2;
    localparam logic [9:0] DIR_ZERO_LOW      = 10'd5;
    localparam logic [9:0] DIR_SLOT          = 10'd7;
    localparam logic [9:0] DIR_READ_SAMPLE   = 10'd3;
    localparam int BYTE_TICKS = BITS_PER_BYTE * int'(DIR_SLOT);

    typedef struct packed {
        logic       pull_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_seen;
        logic [7:0] read_value;
    } bus_result_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data_byte;
        logic        bus_level;
        int          reps;
        logic        known;
        bus_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    owbm_req_if req_ch ();
    owbm_rsp_if rsp_ch ();
    owbm_cfg_if cfg_ch ();

    one_wire_bus_master i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // timing registers as the predictor sees them
    logic [9:0] reg_reset_low;
    logic [7:0] reg_presence_wait;
    logic [9:0] reg_presence_rest;
    logic [5:0] reg_one_low;
    logic [6:0] reg_zero_low;
    logic [7:0] reg_slot;
    logic [6:0] reg_read_sample;

    // predicted sequencer state
    phase_t     bus_phase;
    logic [9:0] bus_count;
    logic [2:0] bus_bit;
    logic [7:0] bus_shift;
    logic       bus_presence;
    logic [7:0] bus_last_read;
    logic       bus_drive;

    bus_result_t expected_bus_results [$];

    int   err_count = 0;
    int   cycle_count = 0;
    logic no_idle;
    logic hold_kick;

    // expected value typed in where it is plain, otherwise taken from the predictor
    stim_row_t directed_rows [N_ROWS] = '{
        // ticks while idle after reset
        '{OP_TICK,  8'hFF, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{OP_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
        // reset, then every command while busy is dropped
        '{OP_RESET, 8'hA5, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{OP_READ,  8'h00, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{OP_WRITE, 8'hFF, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{OP_RESET, 8'h3C, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{OP_TICK,  8'h00, 1'b1, int'(DIR_RESET_LOW), 1'b0, '0},
        '{OP_TICK,  8'h00, 1'b1, int'(DIR_PRESENCE_WAIT) - 1, 1'b0, '0},
        // device answers on the presence sample
        '{OP_TICK,  8'hFF, 1'b0, 1, 1'b0, '0},
        '{OP_TICK,  8'h00, 1'b1, int'(DIR_PRESENCE_REST) - 1, 1'b0, '0},
        '{OP_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00}},
        // write all ones, then all zeros
        '{OP_WRITE, 8'hFF, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
        '{OP_TICK,  8'h00, 1'b0, BYTE_TICKS, 1'b0, '0},
        '{OP_WRITE, 8'h00, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
        '{OP_TICK,  8'hFF, 1'b1, BYTE_TICKS, 1'b0, '0},
        // read with the bus high, then low
        '{OP_READ,  8'h5A, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
        '{OP_TICK,  8'h00, 1'b1, BYTE_TICKS, 1'b0, '0},
        '{OP_READ,  8'hFF, 1'b1, 1, 1'b0, '0},
        '{OP_TICK,  8'hFF, 1'b0, BYTE_TICKS, 1'b0, '0},
        // reset with no device on the bus
        '{OP_RESET, 8'h00, 1'b0, 1, 1'b0, '0},
        '{OP_TICK,  8'h00, 1'b1,
          int'(DIR_RESET_LOW) + int'(DIR_PRESENCE_WAIT) + int'(DIR_PRESENCE_REST), 1'b0, '0},
        '{OP_TICK,  8'hFF, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}}
    };

    function automatic logic [9:0] nonzero_len(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [9:0] rand_timing(input int small_max);
        if ($urandom_range(0, 4) == 0)
            return 10'($urandom_range(0, 4 * small_max));
        return 10'($urandom_range(0, small_max));
    endfunction

    task automatic reset_bus_model();
        reg_reset_low     = RST_RESET_LOW;
        reg_presence_wait = RST_PRESENCE_WAIT;
        reg_presence_rest = RST_PRESENCE_REST;
        reg_one_low       = RST_ONE_LOW;
        reg_zero_low      = RST_ZERO_LOW;
        reg_slot          = RST_SLOT;
        reg_read_sample   = RST_READ_SAMPLE;
        bus_phase         = PH_IDLE;
        bus_count         = '0;
        bus_bit           = '0;
        bus_shift         = '0;
        bus_presence      = 1'b0;
        bus_last_read     = '0;
        bus_drive         = 1'b0;
    endtask

    // closes one bit slot, flags the end of the byte
    task automatic advance_slot(output logic last_bit);
        if (bus_bit >= LAST_BIT)
        begin
            bus_bit  = '0;
            last_bit = 1'b1;
        end
        else
        begin
            bus_bit   = bus_bit + 3'd1;
            bus_count = '0;
            bus_drive = 1'b1;
            last_bit  = 1'b0;
        end
    endtask

    task automatic predict_bus_step(input op_t op, input logic [7:0] data, input logic level,
                                    output bus_result_t res);
        logic [9:0] slot_len;
        logic [9:0] sample_pt;
        logic [9:0] low_len;
        logic       last_bit;
        logic       finished;
        slot_len = nonzero_len(10'(reg_slot));
        finished = 1'b0;
        if (op != OP_TICK)
        begin
            if (bus_phase == PH_IDLE)
            begin
                bus_count = '0;
                bus_bit   = '0;
                bus_drive = 1'b1;
                if (op == OP_RESET)
                begin
                    bus_phase    = PH_RST_LOW;
                    bus_presence = 1'b0;
                end
                else if (op == OP_WRITE)
                begin
                    bus_phase = PH_WRITE;
                    bus_shift = data;
                end
                else
                begin
                    bus_phase = PH_READ;
                    bus_shift = '0;
                end
            end
        end
        else if (bus_phase != PH_IDLE)
        begin
            bus_count = bus_count + 10'd1;
            case (bus_phase)
                PH_RST_LOW:
                begin
                    bus_drive = 1'b1;
                    if (bus_count >= nonzero_len(reg_reset_low))
                    begin
                        bus_phase = PH_RST_WAIT;
                        bus_count = '0;
                        bus_drive = 1'b0;
                    end
                end
                PH_RST_WAIT:
                begin
                    bus_drive = 1'b0;
                    if (bus_count >= nonzero_len(10'(reg_presence_wait)))
                    begin
                        bus_presence = ~level;
                        bus_count    = '0;
                        if (reg_presence_rest == 10'd0)
                        begin
                            bus_phase = PH_IDLE;
                            finished  = 1'b1;
                        end
                        else
                        begin
                            bus_phase = PH_RST_REST;
                        end
                    end
                end
                PH_RST_REST:
                begin
                    bus_drive = 1'b0;
                    if (bus_count >= reg_presence_rest)
                    begin
                        bus_phase = PH_IDLE;
                        finished  = 1'b1;
                    end
                end
                PH_WRITE:
                begin
                    low_len   = bus_shift[0] ? 10'(reg_one_low) : 10'(reg_zero_low);
                    bus_drive = bus_count < low_len;
                    if (bus_count >= slot_len)
                    begin
                        bus_shift = bus_shift >> 1;
                        advance_slot(last_bit);
                        if (last_bit)
                        begin
                            bus_phase = PH_IDLE;
                            bus_drive = 1'b0;
                            finished  = 1'b1;
                        end
                    end
                end
                PH_READ:
                begin
                    sample_pt = nonzero_len(10'(reg_read_sample));
                    if (sample_pt > slot_len)
                        sample_pt = slot_len;
                    bus_drive = bus_count < 10'(reg_one_low);
                    if (bus_count == sample_pt)
                        bus_shift = {level, bus_shift[7:1]};
                    if (bus_count >= slot_len)
                    begin
                        advance_slot(last_bit);
                        if (last_bit)
                        begin
                            bus_last_read = bus_shift;
                            bus_phase     = PH_IDLE;
                            bus_drive     = 1'b0;
                            finished      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    bus_phase = PH_IDLE;
                    bus_drive = 1'b0;
                end
            endcase
        end
        if (bus_phase == PH_IDLE)
            bus_drive = 1'b0;
        res.pull_low      = bus_drive;
        res.busy_res      = bus_phase != PH_IDLE;
        res.done_res      = finished;
        res.presence_seen = bus_presence;
        res.read_value    = bus_last_read;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_bus_result();
        bus_result_t want;
        if (expected_bus_results.size() == 0)
        begin
            report_mismatch("result transfer with nothing expected", 8'(rsp_ch.pull_low), 8'h0);
        end
        else
        begin
            want = expected_bus_results.pop_front();
            if (rsp_ch.pull_low !== want.pull_low)
                report_mismatch("pull_low", 8'(rsp_ch.pull_low), 8'(want.pull_low));
            if (rsp_ch.busy_res !== want.busy_res)
                report_mismatch("busy_res", 8'(rsp_ch.busy_res), 8'(want.busy_res));
            if (rsp_ch.done_res !== want.done_res)
                report_mismatch("done_res", 8'(rsp_ch.done_res), 8'(want.done_res));
            if (rsp_ch.presence_seen !== want.presence_seen)
                report_mismatch("presence_seen", 8'(rsp_ch.presence_seen),
                                8'(want.presence_seen));
            if (rsp_ch.read_value !== want.read_value)
                report_mismatch("read_value", rsp_ch.read_value, want.read_value);
        end
    endtask

    task automatic send_item(input op_t op, input logic [7:0] data, input logic level,
                             input logic known, input bus_result_t known_res);
        bus_result_t predicted;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.func      = op;
        req_ch.data_byte = data;
        req_ch.bus_level = level;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_bus_step(op, data, level, predicted);
        expected_bus_results.push_back(known ? known_res : predicted);
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_bus_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timing_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_RESET_LOW:     reg_reset_low     = value;
            CFG_PRESENCE_WAIT: reg_presence_wait = value[7:0];
            CFG_PRESENCE_REST: reg_presence_rest = value;
            CFG_ONE_LOW:       reg_one_low       = value[5:0];
            CFG_ZERO_LOW:      reg_zero_low      = value[6:0];
            CFG_SLOT:          reg_slot          = value[7:0];
            CFG_READ_SAMPLE:   reg_read_sample   = value[6:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic program_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                                  input logic [9:0] pres_rest, input logic [9:0] one_low,
                                  input logic [9:0] zero_low, input logic [9:0] slot,
                                  input logic [9:0] sample);
        settle_idle();
        write_timing_reg(CFG_RESET_LOW, rst_low);
        write_timing_reg(CFG_PRESENCE_WAIT, pres_wait);
        write_timing_reg(CFG_PRESENCE_REST, pres_rest);
        write_timing_reg(CFG_ONE_LOW, one_low);
        write_timing_reg(CFG_ZERO_LOW, zero_low);
        write_timing_reg(CFG_SLOT, slot);
        write_timing_reg(CFG_READ_SAMPLE, sample);
    endtask

    // mostly complete commands with random bus levels, some dropped commands and idle ticks
    task automatic run_phase(input int n_items);
        int   counted;
        op_t  op;
        logic busy;
        counted = 0;
        while (counted < n_items)
        begin
            busy = bus_phase != PH_IDLE;
            if (!busy)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    op = op_t'($urandom_range(1, 3));
                    counted++;
                end
                else
                begin
                    op = OP_TICK;
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < 7)
                begin
                    op = op_t'($urandom_range(1, 3));
                end
                else
                begin
                    op = OP_TICK;
                    counted++;
                end
            end
            send_item(op, 8'($urandom), 1'($urandom), 1'b0, '0);
        end
        while (bus_phase != PH_IDLE)
            send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_bus_result();
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int   hold_left;
        logic seen_kick;
        hold_left    = 0;
        seen_kick    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_kick != seen_kick)
            begin
                seen_kick = hold_kick;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial
    begin
        stim_row_t row;
        no_idle          = 1'b0;
        hold_kick        = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = OP_TICK;
        req_ch.data_byte = '0;
        req_ch.bus_level = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        reset_bus_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short timings keep the directed byte and reset sequences brief
        program_timing(DIR_RESET_LOW, DIR_PRESENCE_WAIT, DIR_PRESENCE_REST, DIR_ONE_LOW,
                       DIR_ZERO_LOW, DIR_SLOT, DIR_READ_SAMPLE);
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = directed_rows[i];
            for (int r = 0; r < row.reps; r++)
                send_item(row.op, row.data_byte, row.bus_level, row.known, row.res);
        end

        // zero lengths and a rest of zero
        program_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_phase(60);
        // lowest legal timings
        program_timing(10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd2, 10'd1);
        run_phase(60);
        // low times covering the whole slot, sample point past the slot end
        program_timing(10'd5, 10'd3, 10'd2, 10'd63, 10'd127, 10'd8, 10'd127);
        run_phase(100);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            program_timing(rand_timing(24), rand_timing(12), rand_timing(24), rand_timing(10),
                           rand_timing(16), rand_timing(20), rand_timing(24));
            no_idle = (p == 2);
            // results held back while requests keep coming, so the queue fills up
            if (p == 4)
                hold_kick = ~hold_kick;
            run_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        settle_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
